// File: rtl/rvmm_pkg.sv
// ----------------------------------------------------------------------------
// rvmm_pkg
// Shared types and constants for the row vector by matrix multiply block.
// ----------------------------------------------------------------------------
package rvmm_pkg;

  // Built sizes
  localparam int MAX_SIZE = 16;
  localparam int IDX_W    = 4;   // bits of a row or column index
  localparam int DATA_W   = 32;
  localparam int SIZE_W   = 5;   // matrix_size register width
  localparam int MAT_AW   = 2 * IDX_W;
  localparam int CFG_AW   = 3;   // byte address of the register file
  localparam int CFG_DW   = 32;

  // Register index, taken from the word part of paddr
  localparam logic REG_MATRIX_SIZE = 1'b0;

  // Reset value of matrix_size
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_SIZE);

  // Item action codes
  typedef enum logic [1:0] {
    ACT_LOAD_VEC = 2'd0,
    ACT_LOAD_MAT = 2'd1,
    ACT_COMPUTE  = 2'd2
  } action_e;

  // Input item
  typedef struct packed {
    action_e                   action;
    logic [IDX_W-1:0]          row_index;
    logic [IDX_W-1:0]          col_index;
    logic signed [DATA_W-1:0]  element_value;
  } item_t;

  // Result item
  typedef struct packed {
    logic [IDX_W-1:0]          column;
    logic signed [DATA_W-1:0]  dot_product;
    logic                      last;
  } result_t;

  // One multiply-accumulate step issued by the controller
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] k;        // vector position / matrix row
    logic [IDX_W-1:0] j;        // matrix column
    logic             first;    // first term of a column sum
    logic             last_k;   // last term of a column sum
    logic             last_col; // final column of the row
  } issue_t;

endpackage

// File: rtl/rvmm_ram.sv
// ----------------------------------------------------------------------------
// rvmm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rvmm_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/rvmm_ctrl.sv
// ----------------------------------------------------------------------------
// rvmm_ctrl
// Sequencer: walks columns and terms of a compute item, one MAC step a cycle.
// ----------------------------------------------------------------------------
module rvmm_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         compute_i,  // compute item accepted
  input  logic [rvmm_pkg::SIZE_W-1:0]  size_i,
  output logic                         busy_o,
  output rvmm_pkg::issue_t             issue_o
);
  import rvmm_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] k_q, k_d;
  logic [IDX_W-1:0] j_q, j_d;
  logic [IDX_W-1:0] nm1_q, nm1_d;
  logic [SIZE_W-1:0] n_sat;

  // Active size, saturated to the built maximum
  assign n_sat = (size_i > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : size_i;

  // Next state
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    j_d     = j_q;
    nm1_d   = nm1_q;
    case (state_q)
      ST_IDLE: begin
        if (compute_i && (n_sat != '0)) begin
          state_d = ST_RUN;
          k_d     = '0;
          j_d     = '0;
          nm1_d   = IDX_W'(n_sat - SIZE_W'(1));
        end
      end
      ST_RUN: begin
        if (k_q == nm1_q) begin
          k_d = '0;
          j_d = j_q + IDX_W'(1);
          if (j_q == nm1_q) begin
            state_d = ST_IDLE;
          end
        end else begin
          k_d = k_q + IDX_W'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      j_q     <= '0;
      nm1_q   <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      j_q     <= j_d;
      nm1_q   <= nm1_d;
    end
  end

  // Commands to the datapath
  assign busy_o            = (state_q == ST_RUN);
  assign issue_o.valid     = (state_q == ST_RUN);
  assign issue_o.k         = k_q;
  assign issue_o.j         = j_q;
  assign issue_o.first     = (k_q == '0);
  assign issue_o.last_k    = (k_q == nm1_q);
  assign issue_o.last_col  = (j_q == nm1_q);

endmodule

// File: rtl/rvmm_dp.sv
// ----------------------------------------------------------------------------
// rvmm_dp
// Datapath: vector and matrix stores, multiplier and accumulator.
// ----------------------------------------------------------------------------
module rvmm_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,  // input item accepted
  input  rvmm_pkg::item_t     item_i,
  input  rvmm_pkg::issue_t    issue_i,
  output logic                res_valid_o,
  output rvmm_pkg::result_t   res_o
);
  import rvmm_pkg::*;

  logic               vec_we, mat_we;
  logic [DATA_W-1:0]  vec_rdata, mat_rdata;
  logic [DATA_W-1:0]  prod_lo;

  // Stage 1: RAM read in flight
  logic               v1_q;
  logic               first1_q, lastk1_q, lastcol1_q;
  logic [IDX_W-1:0]   col1_q;
  // Stage 2: product registered
  logic               v2_q;
  logic               first2_q, lastk2_q, lastcol2_q;
  logic [IDX_W-1:0]   col2_q;
  logic [DATA_W-1:0]  prod_q;
  // Stage 3: accumulator and result
  logic [DATA_W-1:0]  acc_q, sum_d;
  logic               res_valid_q;
  result_t            res_q;

  // Load decode; indices are 4 bits, so always inside the built size
  assign vec_we = accept_i && (item_i.action == ACT_LOAD_VEC);
  assign mat_we = accept_i && (item_i.action == ACT_LOAD_MAT);

  rvmm_ram #(
    .Width (DATA_W),
    .Depth (MAX_SIZE)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (vec_we),
    .waddr_i (item_i.col_index),
    .wdata_i (item_i.element_value),
    .raddr_i (issue_i.k),
    .rdata_o (vec_rdata)
  );

  rvmm_ram #(
    .Width (DATA_W),
    .Depth (MAX_SIZE * MAX_SIZE)
  ) u_mat_ram (
    .clk_i   (clk_i),
    .we_i    (mat_we),
    .waddr_i ({item_i.row_index, item_i.col_index}),
    .wdata_i (item_i.element_value),
    .raddr_i ({issue_i.k, issue_i.j}),
    .rdata_o (mat_rdata)
  );

  // Product, low word only (wraps as 32-bit arithmetic)
  assign prod_lo = vec_rdata * mat_rdata;

  // Column sum
  assign sum_d = (first2_q ? '0 : acc_q) + prod_q;

  // Pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      v1_q        <= issue_i.valid;
      v2_q        <= v1_q;
      res_valid_q <= v2_q && lastk2_q;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    first1_q   <= issue_i.first;
    lastk1_q   <= issue_i.last_k;
    lastcol1_q <= issue_i.last_col;
    col1_q     <= issue_i.j;

    first2_q   <= first1_q;
    lastk2_q   <= lastk1_q;
    lastcol2_q <= lastcol1_q;
    col2_q     <= col1_q;
    prod_q     <= prod_lo;

    if (v2_q) begin
      acc_q <= sum_d;
    end
    res_q.column      <= col2_q;
    res_q.dot_product <= sum_d;
    res_q.last        <= lastcol2_q;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// File: rtl/row_vector_matrix_multiply.sv
// Load items never raise busy; the next item may follow at once.
// A compute item of active size n keeps busy high while it issues n*n MAC
// steps, one a cycle through the shared multiplier and the two RAM read ports.
// Column j's result strobes after its last MAC step's RAM read and product stages.
// Reset clears control and sets matrix_size to 16; stores are not cleared.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// row_vector_matrix_multiply
// Top level: APB register, controller and datapath of a row vector by matrix
// multiply.
// ----------------------------------------------------------------------------
module row_vector_matrix_multiply (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Item channel
  input  logic                          start,
  output logic                          busy,
  input  rvmm_pkg::item_t               cmd_i,
  output logic                          res_valid_o,
  output rvmm_pkg::result_t             res_o,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rvmm_pkg::CFG_AW-1:0]   paddr,
  input  logic [rvmm_pkg::CFG_DW-1:0]   pwdata,
  output logic [rvmm_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);
  import rvmm_pkg::*;

  logic              accept;
  logic              compute;
  logic              cfg_we;
  logic [SIZE_W-1:0] size_q;
  issue_t            issue;

  // Item handshake
  assign accept  = start && !busy;
  assign compute = accept && (cmd_i.action == ACT_COMPUTE);

  // Configuration register
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready
                  && (paddr[CFG_AW-1] == REG_MATRIX_SIZE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (cfg_we) begin
      size_q <= pwdata[SIZE_W-1:0];
    end
  end

  assign prdata = (paddr[CFG_AW-1] == REG_MATRIX_SIZE)
                  ? CFG_DW'(size_q) : '0;

  rvmm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .compute_i (compute),
    .size_i    (size_q),
    .busy_o    (busy),
    .issue_o   (issue)
  );

  rvmm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (cmd_i),
    .issue_i     (issue),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the row vector by matrix multiply block. A
// directed table covers the operand extremes, the size register edge cases,
// the unused action and loads past the active size; random phases then mix
// loads, computes and noise under random sizes and random idle gaps. Every
// result column is checked field by field against the directed table or a bench-side predictor.
// ----------------------------------------------------------------------------
module tb;
  import rvmm_pkg::*;

  localparam int CYCLE_LIMIT      = 400_000;
  localparam int SETTLE           = 8;
  localparam int RANDOM_ITEMS     = 40;
  localparam int MAX_GAP          = 16;
  localparam int SHOWN_MISMATCHES = 10;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [CFG_AW-1:0] SIZE_ADDR = CFG_AW'({REG_MATRIX_SIZE, 2'b00});

  // One row of the directed table: a size write or an item
  typedef struct packed {
    bit                 is_cfg;
    logic [SIZE_W-1:0]  size;
    item_t              cmd;
    bit                 typed;   // dot below is the one expected column
    logic [DATA_W-1:0]  dot;
  } plan_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  item_t             cmd_i;
  logic              res_valid_o;
  result_t           res_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  // Predictor state
  logic [DATA_W-1:0] vec_mem [MAX_SIZE];
  logic [DATA_W-1:0] mat_mem [MAX_SIZE][MAX_SIZE];
  logic [SIZE_W-1:0] size_reg;
  result_t           expected_columns [$];
  result_t           want_col;

  int  mismatches;
  int  columns_seen;
  int  items_sent;
  int  computes_sent;
  int  settings_used;
  int  cycle_count;
  bit  idle_on;

  row_vector_matrix_multiply uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  // Sizes above the built maximum saturate
  function automatic int active_size();
    return (size_reg > MAX_SIZE) ? MAX_SIZE : int'(size_reg);
  endfunction

  // Apply one accepted item to the predictor; a compute queues its columns
  task automatic track_item(item_t it);
    logic [DATA_W-1:0] acc;
    result_t           col;
    int                n;
    case (it.action)
      ACT_LOAD_VEC: vec_mem[it.col_index] = it.element_value;
      ACT_LOAD_MAT: mat_mem[it.row_index][it.col_index] = it.element_value;
      ACT_COMPUTE: begin
        n = active_size();
        for (int j = 0; j < n; j++) begin
          acc = '0;
          for (int k = 0; k < n; k++) acc = acc + vec_mem[k] * mat_mem[k][j];
          col.column      = IDX_W'(j);
          col.dot_product = acc;
          col.last        = (j == n - 1);
          expected_columns.push_back(col);
        end
      end
      default: ;
    endcase
  endtask

  // Present one item, after a random gap when idle mode is on, and hold it until accepted
  task automatic drive_item(item_t it, bit typed, logic [DATA_W-1:0] dot);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= it;
    do @(posedge clk_i); while (busy);
    if (typed) expected_columns.push_back('{column: '0, dot_product: dot, last: 1'b1});
    else track_item(it);
    if (it.action == ACT_COMPUTE) computes_sent++;
    if (it.action != action_e'(ACT_UNUSED)) items_sent++;
  endtask

  // Stop issuing and let every pending column come out
  task automatic wait_drained();
    start <= 1'b0;
    while (expected_columns.size() != 0 || busy) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // APB write of matrix_size: setup then access phase
  task automatic cfg_write(logic [SIZE_W-1:0] sz);
    logic [CFG_DW-1:0] word;
    word = $urandom;
    word[SIZE_W-1:0] = sz;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SIZE_ADDR;
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    size_reg = sz;
    settings_used++;
  endtask

  // Operand values with extremes weighted in
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '1;
      3:       return DATA_W'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  // Mostly loads inside the active square, some computes, some noise
  function automatic item_t random_item(int n);
    item_t it;
    int    pick;
    pick             = $urandom_range(0, 19);
    it.row_index     = IDX_W'($urandom);
    it.col_index     = IDX_W'($urandom);
    it.element_value = $urandom;
    if (pick < 2) begin
      it.action = action_e'(ACT_UNUSED);
    end else if (pick < 5) begin
      it.action = ACT_COMPUTE;
    end else begin
      it.action        = pick[0] ? ACT_LOAD_MAT : ACT_LOAD_VEC;
      it.element_value = pick_value();
      if (n > 0 && pick < 17) begin
        it.row_index = IDX_W'($urandom_range(0, n - 1));
        it.col_index = IDX_W'($urandom_range(0, n - 1));
      end
    end
    return it;
  endfunction

  function automatic plan_row_t item_row(action_e act, logic [IDX_W-1:0] r,
                                         logic [IDX_W-1:0] c, logic [DATA_W-1:0] v,
                                         bit typed = 1'b0, logic [DATA_W-1:0] dot = '0);
    plan_row_t row;
    row        = '0;
    row.cmd    = '{action: act, row_index: r, col_index: c, element_value: v};
    row.typed  = typed;
    row.dot    = dot;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(logic [SIZE_W-1:0] sz);
    plan_row_t row;
    row        = '0;
    row.is_cfg = 1'b1;
    row.size   = sz;
    return row;
  endfunction

  // Column checker
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      columns_seen++;
      if (expected_columns.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display("unexpected column: col %0d dot %0d last %0b",
                   res_o.column, res_o.dot_product, res_o.last);
      end else begin
        want_col = expected_columns.pop_front();
        if (res_o.column !== want_col.column || res_o.dot_product !== want_col.dot_product ||
            res_o.last !== want_col.last) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES)
            $display("column differs: expected col %0d dot %0d last %0b, got col %0d dot %0d last %0b",
                     want_col.column, want_col.dot_product, want_col.last,
                     res_o.column, res_o.dot_product, res_o.last);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("row_vector_matrix_multiply: mismatch");
      $finish;
    end
  end

  // Stimulus
  initial begin
    plan_row_t plan [$];
    item_t     it;
    int        n;
    int        sz;
    int        base;
    start    <= 1'b0;
    cmd_i    <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    rst_ni   <= 1'b0;
    size_reg = SIZE_RESET;
    idle_on  = 1'b1;

    // Size 1: wrap of products at the operand extremes
    plan.push_back(cfg_row(5'd1));
    plan.push_back(item_row(ACT_LOAD_VEC, 4'hF, 4'd0, 32'h7FFF_FFFF));
    plan.push_back(item_row(ACT_LOAD_MAT, 4'd0, 4'd0, 32'h7FFF_FFFF));
    plan.push_back(item_row(ACT_COMPUTE, 4'd0, 4'd0, 32'd0, 1'b1, 32'd1));
    // compute ignores its other fields
    plan.push_back(item_row(ACT_COMPUTE, 4'hF, 4'hF, '1, 1'b1, 32'd1));
    plan.push_back(item_row(ACT_LOAD_VEC, 4'd0, 4'd0, 32'h8000_0000));
    plan.push_back(item_row(ACT_COMPUTE, 4'd0, 4'd0, 32'd0, 1'b1, 32'h8000_0000));
    plan.push_back(item_row(ACT_LOAD_MAT, 4'd0, 4'd0, 32'h8000_0000));
    plan.push_back(item_row(ACT_COMPUTE, 4'd0, 4'd0, 32'd0, 1'b1, 32'd0));
    plan.push_back(item_row(ACT_LOAD_VEC, 4'd0, 4'd0, '1));
    plan.push_back(item_row(ACT_COMPUTE, 4'd0, 4'd0, 32'd0, 1'b1, 32'h8000_0000));
    // unused action emits nothing
    plan.push_back(item_row(action_e'(ACT_UNUSED), 4'hF, 4'hF, '1));
    // loads past the active size are still stored
    plan.push_back(item_row(ACT_LOAD_VEC, 4'd0, 4'd1, 32'd3));
    plan.push_back(item_row(ACT_LOAD_MAT, 4'd1, 4'd0, 32'h7FFF_FFFF));
    plan.push_back(item_row(ACT_LOAD_MAT, 4'd0, 4'd1, 32'd5));
    plan.push_back(item_row(ACT_LOAD_MAT, 4'd1, 4'd1, 32'd0));
    plan.push_back(item_row(ACT_LOAD_VEC, 4'd0, 4'hF, 32'h1234_5678));
    plan.push_back(item_row(ACT_LOAD_MAT, 4'hF, 4'hF, 32'h5A5A_5A5A));
    // size zero: compute emits nothing
    plan.push_back(cfg_row(5'd0));
    plan.push_back(item_row(ACT_COMPUTE, 4'd0, 4'd0, 32'd0));
    plan.push_back(cfg_row(5'd2));
    plan.push_back(item_row(ACT_COMPUTE, 4'd3, 4'd9, 32'd7));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_drained();
        cfg_write(plan[i].size);
      end else begin
        drive_item(plan[i].cmd, plan[i].typed, plan[i].dot);
      end
    end

    // Fill the whole store under an oversized setting, then full-size computes
    wait_drained();
    cfg_write(5'd31);
    for (int r = 0; r < MAX_SIZE; r++) begin
      for (int c = 0; c < MAX_SIZE; c++) begin
        it = '{action: ACT_LOAD_MAT, row_index: IDX_W'(r), col_index: IDX_W'(c),
               element_value: pick_value()};
        drive_item(it, 1'b0, '0);
      end
    end
    for (int c = 0; c < MAX_SIZE; c++) begin
      it = '{action: ACT_LOAD_VEC, row_index: IDX_W'($urandom), col_index: IDX_W'(c),
             element_value: pick_value()};
      drive_item(it, 1'b0, '0);
    end
    it = '{action: ACT_COMPUTE, row_index: IDX_W'($urandom), col_index: IDX_W'($urandom),
           element_value: $urandom};
    drive_item(it, 1'b0, '0);
    wait_drained();
    cfg_write(5'd16);
    drive_item(it, 1'b0, '0);

    // Random phases, each under its own size and idle mode
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0:       sz = 0;
        1:       sz = MAX_SIZE;
        2:       sz = $urandom_range(17, 31);
        default: sz = $urandom_range(1, 6);
      endcase
      wait_drained();
      cfg_write(SIZE_W'(sz));
      n = active_size();
      repeat ($urandom_range(10, 30)) drive_item(random_item(n), 1'b0, '0);
    end

    wait_drained();
    $display("covered %0d items (%0d computes) over %0d size settings", items_sent,
             computes_sent, settings_used);
    $display("checked %0d result columns, %0d mismatches", columns_seen, mismatches);
    if (mismatches == 0 && expected_columns.size() == 0) begin
      $display("row_vector_matrix_multiply: match");
    end else begin
      $display("row_vector_matrix_multiply: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/rvmm_pkg.sv
rtl/rvmm_ram.sv
rtl/rvmm_ctrl.sv
rtl/rvmm_dp.sv
rtl/row_vector_matrix_multiply.sv
verif/tb.sv
